// ----- hdl/prcf_pkg.sv -----
// Shared types and constants for the reverse Chaikin polyline filter.
// No dependencies; used by every module of the filter.
package prcf_pkg;

	// Default coordinate width (signed Q16.16)
	localparam int COORD_BITS_DEF = 32;

	// Distance counter since the last base point
	localparam int DIST_BITS = 2;
	typedef logic [DIST_BITS-1:0] dist_t;

	localparam dist_t DIST_BASE        = 2'd0;
	localparam dist_t DIST_AFTER_BLEND = 2'd1;
	localparam dist_t DIST_BLEND       = 2'd3;

	// Work still owed by the input stage register
	typedef struct packed {
		logic vld;    // stage holds an item with words left to send
		logic blend;  // a continuous (blended) word is still to go
		logic point;  // the item's own point is still to go
		logic exact;  // exact flag of the item's own point
	} s1_flags_t;

endpackage

// ----- hdl/prcf_blend.sv -----
// One axis of the continuous point: (3*(p1+p2) - (p0+p3)) / 4, floor, saturated.
// Purely combinational; takes its default width from prcf_pkg.
module prcf_blend #(
	parameter int W = prcf_pkg::COORD_BITS_DEF
) (
	input  logic [W-1:0] p0,
	input  logic [W-1:0] p1,
	input  logic [W-1:0] p2,
	input  logic [W-1:0] p3,
	output logic [W-1:0] q
);

	logic [W+3:0] sum12;
	logic [W+3:0] sum03;
	logic [W+3:0] acc;
	logic [W+1:0] quot;
	logic         ovf;

	// Exact sum on W+4 bits, then floor divide by 4 with an arithmetic shift
	always_comb begin
		sum12 = {{4{p1[W-1]}}, p1} + {{4{p2[W-1]}}, p2};
		sum03 = {{4{p0[W-1]}}, p0} + {{4{p3[W-1]}}, p3};
		acc   = {sum12[W+2:0], 1'b0} + sum12 - sum03;
		quot  = acc[W+3:2];
		// Out of range when the top three bits disagree
		ovf   = !((quot[W+1:W-1] == 3'b000) || (quot[W+1:W-1] == 3'b111));
		if (!ovf) begin
			q = quot[W-1:0];
		end else if (quot[W+1]) begin
			q = {1'b1, {(W-1){1'b0}}};
		end else begin
			q = {1'b0, {(W-1){1'b1}}};
		end
	end

endmodule

// ----- hdl/prcf_stage.sv -----
// Input stage: point window, distance counter and the input register (_s1).
// Depends on prcf_pkg for the counter type and the stage flag struct.
module prcf_stage #(
	parameter int W = prcf_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [W-1:0]          x_coord,
	input  logic [W-1:0]          y_coord,
	input  logic [W-1:0]          z_coord,
	input  logic                  is_exact,
	input  logic                  in_run,
	input  logic                  take,
	output prcf_pkg::s1_flags_t   flags_s1,
	output logic [W-1:0]          x_s1,
	output logic [W-1:0]          y_s1,
	output logic [W-1:0]          z_s1,
	output logic [2:0][W-1:0]     wx_s1,
	output logic [2:0][W-1:0]     wy_s1,
	output logic [2:0][W-1:0]     wz_s1
);

	logic [2:0][W-1:0]   win_x_q;
	logic [2:0][W-1:0]   win_y_q;
	logic [2:0][W-1:0]   win_z_q;
	prcf_pkg::dist_t     dist_q;
	logic                prev_run_q;
	prcf_pkg::s1_flags_t flags_q;

	logic                accept;
	logic                split;
	prcf_pkg::dist_t     dist_step;
	prcf_pkg::dist_t     dist_next;
	logic                blend_hit;

	// A word with two results holds the stage for a second word
	assign split    = flags_q.blend && flags_q.point;
	assign in_ready = !flags_q.vld || (take && !split);
	assign accept   = in_valid && in_ready;

	// Advance the distance counter for an in-run point
	always_comb begin
		dist_step = prev_run_q ? (dist_q + prcf_pkg::dist_t'(1)) : prcf_pkg::DIST_BASE;
		blend_hit = in_run && (dist_step == prcf_pkg::DIST_BLEND);
		dist_next = blend_hit ? prcf_pkg::DIST_AFTER_BLEND : dist_step;
		if (is_exact) begin
			dist_next = prcf_pkg::DIST_BASE;
		end
	end

	// Control state: counter, run flag and stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q     <= prcf_pkg::DIST_BASE;
			prev_run_q <= 1'b0;
			flags_q    <= '0;
		end else if (accept) begin
			prev_run_q    <= in_run;
			if (in_run) begin
				dist_q <= dist_next;
			end
			flags_q.vld   <= blend_hit || is_exact || !in_run;
			flags_q.blend <= blend_hit;
			flags_q.point <= is_exact || !in_run;
			flags_q.exact <= is_exact;
		end else if (take && flags_q.vld) begin
			if (split) begin
				flags_q.blend <= 1'b0;
			end else begin
				flags_q.vld <= 1'b0;
			end
		end
	end

	// Capture the point with the window as it stood, then shift the window
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= x_coord;
			y_s1    <= y_coord;
			z_s1    <= z_coord;
			wx_s1   <= win_x_q;
			wy_s1   <= win_y_q;
			wz_s1   <= win_z_q;
			win_x_q <= {x_coord, win_x_q[2:1]};
			win_y_q <= {y_coord, win_y_q[2:1]};
			win_z_q <= {z_coord, win_z_q[2:1]};
		end
	end

	assign flags_s1 = flags_q;

endmodule

// ----- hdl/polyline_reverse_chaikin_filter.sv -----
// Top level of the reverse Chaikin polyline filter: input stage, blend logic,
// result register. Depends on prcf_pkg, prcf_stage and prcf_blend.
//
// An accepted point is registered together with the three points before it;
// the continuous point is blended from those four combinationally and loaded
// into the result register once that is free. One word leaves per cycle while
// out_ready stays high. A point that yields one word frees the input register
// when its word is loaded, and one that yields none leaves it free; a point
// that yields a continuous and an exact word holds it until both are loaded,
// since both go through the single result register. A full result register
// that is being read still accepts a point unless a pair is still pending.
module polyline_reverse_chaikin_filter #(
	parameter int COORD_BITS = prcf_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] x_coord,
	input  logic [COORD_BITS-1:0] y_coord,
	input  logic [COORD_BITS-1:0] z_coord,
	input  logic                  is_exact,
	input  logic                  in_run,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [COORD_BITS-1:0] out_z,
	output logic                  out_exact,
	output logic                  last_result
);

	prcf_pkg::s1_flags_t           flags_s1;
	logic [COORD_BITS-1:0]         x_s1;
	logic [COORD_BITS-1:0]         y_s1;
	logic [COORD_BITS-1:0]         z_s1;
	logic [2:0][COORD_BITS-1:0]    wx_s1;
	logic [2:0][COORD_BITS-1:0]    wy_s1;
	logic [2:0][COORD_BITS-1:0]    wz_s1;
	logic [COORD_BITS-1:0]         bx;
	logic [COORD_BITS-1:0]         by;
	logic [COORD_BITS-1:0]         bz;

	logic                          out_vld_q;
	logic [COORD_BITS-1:0]         out_x_q;
	logic [COORD_BITS-1:0]         out_y_q;
	logic [COORD_BITS-1:0]         out_z_q;
	logic                          out_exact_q;
	logic                          out_last_q;
	logic                          out_free;
	logic                          out_load;

	assign out_free = !out_vld_q || out_ready;
	assign out_load = out_free && flags_s1.vld;

	prcf_stage #(
		.W(COORD_BITS)
	) u_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.z_coord  (z_coord),
		.is_exact (is_exact),
		.in_run   (in_run),
		.take     (out_free),
		.flags_s1 (flags_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.z_s1     (z_s1),
		.wx_s1    (wx_s1),
		.wy_s1    (wy_s1),
		.wz_s1    (wz_s1)
	);

	prcf_blend #(.W(COORD_BITS)) u_blend_x (
		.p0 (wx_s1[0]), .p1 (wx_s1[1]), .p2 (wx_s1[2]), .p3 (x_s1), .q (bx)
	);
	prcf_blend #(.W(COORD_BITS)) u_blend_y (
		.p0 (wy_s1[0]), .p1 (wy_s1[1]), .p2 (wy_s1[2]), .p3 (y_s1), .q (by)
	);
	prcf_blend #(.W(COORD_BITS)) u_blend_z (
		.p0 (wz_s1[0]), .p1 (wz_s1[1]), .p2 (wz_s1[2]), .p3 (z_s1), .q (bz)
	);

	// Result valid: refill when free, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= flags_s1.vld;
		end
	end

	// Load the blended word first, then the point itself
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (flags_s1.blend) begin
				out_x_q     <= bx;
				out_y_q     <= by;
				out_z_q     <= bz;
				out_exact_q <= 1'b0;
				out_last_q  <= !flags_s1.point;
			end else begin
				out_x_q     <= x_s1;
				out_y_q     <= y_s1;
				out_z_q     <= z_s1;
				out_exact_q <= flags_s1.exact;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign out_valid   = out_vld_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;
	assign out_exact   = out_exact_q;
	assign last_result = out_last_q;

	// A non-final word is always followed at once by the exact point
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=> out_valid && out_exact && last_result)
		else $error("second word of a pair did not follow");

	// Non-final words are blended and never exact
	a_blend_not_exact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> !out_exact)
		else $error("non-final word flagged exact");

	// An empty input register always takes a point
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!flags_s1.vld |-> in_ready)
		else $error("input stalled with empty stage");

	// A point outside the run always yields a pass-through word
	a_pass_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_run |=> flags_s1.vld && flags_s1.point && !flags_s1.blend)
		else $error("pass-through point lost");

endmodule
